// File: hdl/xor_float_delta_encoder_unit_macros.svh
// Assertion macros for the XOR float delta encoder.
// Pulled in by the modules that carry concurrent checks; depends on nothing.
`ifndef XOR_FLOAT_DELTA_ENCODER_UNIT_MACROS_SVH
`define XOR_FLOAT_DELTA_ENCODER_UNIT_MACROS_SVH

// cond true on an edge requires expr on the same edge
`define XFDE_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("xfde check failed");

// cond true on an edge requires expr on the next edge
`define XFDE_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("xfde check failed");

`endif

// File: hdl/xfde_pkg.sv
// Shared types and constants for the XOR float delta encoder.
// No dependencies; used by the encoder core, result buffer and top level.
package xfde_pkg;

   localparam int unsigned ValueWidth = 64;
   localparam int unsigned LenWidth   = 7;
   localparam int unsigned LeadWidth  = 5;
   localparam int unsigned MlenWidth  = 6;

   localparam logic [LenWidth-1:0]  FullLength        = 7'd64;
   localparam logic [LenWidth-1:0]  ZeroLength        = 7'd1;
   localparam logic [LenWidth-1:0]  ReuseHeaderLength = 7'd2;
   localparam logic [LenWidth-1:0]  NewHeaderLength   = 7'd13;
   localparam logic [LeadWidth-1:0] LeadCap           = 5'd31;
   localparam logic [1:0]           CtlReuse          = 2'b10;
   localparam logic [1:0]           CtlNewWindow      = 2'b11;

   typedef struct packed {
      logic [ValueWidth-1:0] bits;
      logic [LenWidth-1:0]   length;
      logic                  last;
   } chunk_type;

   typedef struct packed {
      chunk_type head;
      chunk_type tail;
      logic      two;
   } encode_type;

   typedef struct packed {
      logic                  first_pending;
      logic [ValueWidth-1:0] previous_value;
      logic [LeadWidth-1:0]  window_leading;
      logic [LenWidth-1:0]   window_length;
   } state_type;

endpackage

// File: hdl/xfde_encoder.sv
// Combinational encode of one sample against the stored encoder state.
// Depends on xfde_pkg; produces the header/payload chunks and next state.
module xfde_encoder (
   input  logic [xfde_pkg::ValueWidth-1:0] value_bits,
   input  xfde_pkg::state_type             state,
   output xfde_pkg::encode_type            code,
   output xfde_pkg::state_type             next_state
);

   function automatic logic [6:0] count_lead(input logic [63:0] v);
      logic [3:0] grp_cnt [8];
      logic [7:0] grp;
      logic [6:0] n;
      logic       done;
      for (int g = 0; g < 8; g++) begin
         grp        = v[63-8*g -: 8];
         grp_cnt[g] = 4'd8;
         for (int b = 0; b < 8; b++) begin
            if (grp[7-b] && grp_cnt[g] == 4'd8) begin
               grp_cnt[g] = 4'(b);
            end
         end
      end
      n    = 7'd64;
      done = 1'b0;
      for (int g = 0; g < 8; g++) begin
         if (!done && grp_cnt[g] != 4'd8) begin
            n    = 7'(8*g) + {3'b000, grp_cnt[g]};
            done = 1'b1;
         end
      end
      return n;
   endfunction

   logic [63:0] x;
   logic [63:0] x_rev;
   logic [6:0]  lz;
   logic [6:0]  tz;
   logic [4:0]  lead;
   logic [7:0]  mlen_wide;
   logic [7:0]  mlen_m1;
   logic [7:0]  wsum;
   logic [7:0]  wtrail;
   logic        fit;

   always_comb begin
      x = value_bits ^ state.previous_value;
      for (int i = 0; i < 64; i++) begin
         x_rev[i] = x[63-i];
      end
   end

   assign lz        = count_lead(x);
   assign tz        = count_lead(x_rev);
   assign lead      = (lz > 7'd31) ? xfde_pkg::LeadCap : lz[4:0];
   assign mlen_wide = 8'd64 - {3'b000, lead} - {1'b0, tz};
   assign mlen_m1   = mlen_wide - 8'd1;
   assign wsum      = {3'b000, state.window_leading} + {1'b0, state.window_length};
   assign wtrail    = 8'd64 - wsum;
   assign fit       = (state.window_length != 7'd0) && (wsum <= 8'd64)
                      && (lead >= state.window_leading) && ({1'b0, tz} >= wtrail);

   always_comb begin
      next_state                = state;
      next_state.first_pending  = 1'b0;
      next_state.previous_value = value_bits;
      code.two                  = 1'b0;
      code.tail.bits            = x >> tz;
      code.tail.length          = mlen_wide[6:0];
      code.tail.last            = 1'b1;
      code.head.last            = 1'b1;
      if (state.first_pending) begin
         code.head.bits   = value_bits;
         code.head.length = xfde_pkg::FullLength;
      end else if (x == 64'd0) begin
         code.head.bits   = 64'd0;
         code.head.length = xfde_pkg::ZeroLength;
      end else if (fit) begin
         code.two         = 1'b1;
         code.head.bits   = 64'(xfde_pkg::CtlReuse);
         code.head.length = xfde_pkg::ReuseHeaderLength;
         code.head.last   = 1'b0;
         code.tail.bits   = x >> wtrail[6:0];
         code.tail.length = state.window_length;
      end else begin
         code.two                  = 1'b1;
         code.head.bits            = 64'({xfde_pkg::CtlNewWindow, lead, mlen_m1[5:0]});
         code.head.length          = xfde_pkg::NewHeaderLength;
         code.head.last            = 1'b0;
         next_state.window_leading = lead;
         next_state.window_length  = mlen_wide[6:0];
      end
   end

endmodule

// File: hdl/xfde_out_buffer.sv
// Two-slot result register: the presented chunk plus one pending payload chunk.
// Depends on xfde_pkg and the assertion macro header.
`include "xor_float_delta_encoder_unit_macros.svh"

module xfde_out_buffer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  xfde_pkg::encode_type           code,
   output logic                           can_load,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [xfde_pkg::ValueWidth-1:0] rsp_code_bits,
   output logic [xfde_pkg::LenWidth-1:0]  rsp_code_length,
   output logic                           rsp_last_chunk
);

   xfde_pkg::chunk_type out_ff,  out_in;
   xfde_pkg::chunk_type pend_ff, pend_in;
   logic out_valid_ff,  out_valid_in;
   logic pend_valid_ff, pend_valid_in;
   logic take;

   assign take     = out_valid_ff && !rsp_stall;
   assign can_load = !out_valid_ff || (!pend_valid_ff && !rsp_stall);

   always_comb begin
      out_in        = out_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff;
      pend_valid_in = pend_valid_ff;
      if (load) begin
         out_in        = code.head;
         pend_in       = code.tail;
         out_valid_in  = 1'b1;
         pend_valid_in = code.two;
      end else if (take) begin
         out_in        = pend_ff;
         out_valid_in  = pend_valid_ff;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_code_bits   = out_ff.bits;
   assign rsp_code_length = out_ff.length;
   assign rsp_last_chunk  = out_ff.last;

   `XFDE_ASSERT_NOW(pend_needs_out, clock, reset, pend_valid_ff, out_valid_ff)
   `XFDE_ASSERT_NOW(single_is_last, clock, reset, out_valid_ff && !pend_valid_ff, rsp_last_chunk)
   `XFDE_ASSERT_NOW(head_not_last, clock, reset, pend_valid_ff, !rsp_last_chunk)
   `XFDE_ASSERT_NEXT(load_shows, clock, reset, load, rsp_valid && rsp_code_length != 7'd0)

endmodule

// File: hdl/xor_float_delta_encoder_unit.sv
// Channel  Direction  Ports
// req      in         req_valid, req_stall, req_value_bits
// rsp      out        rsp_valid, rsp_stall, rsp_code_bits, rsp_code_length, rsp_last_chunk
// A transaction is registered, encoded in one pass and loaded into the result register,
// which shows its first chunk; a raw or zero-delta sample gives one chunk, others two.
// Sustained rate is one sample per cycle for single-chunk codes while rsp_stall is low;
// a two-chunk code holds the next sample until its payload leaves the two-slot register.
// Synchronous active-high reset clears the state to first-sample mode; req_stall rises while
// the input register holds a transaction and the shown chunk is stalled or a payload is pending.
module xor_float_delta_encoder_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [xfde_pkg::ValueWidth-1:0] req_value_bits,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [xfde_pkg::ValueWidth-1:0] rsp_code_bits,
   output logic [xfde_pkg::LenWidth-1:0]   rsp_code_length,
   output logic                            rsp_last_chunk
);

   logic                            in_valid_ff, in_valid_in;
   logic [xfde_pkg::ValueWidth-1:0] in_value_ff, in_value_in;
   xfde_pkg::state_type             state_ff, state_in;
   xfde_pkg::state_type             next_state;
   xfde_pkg::encode_type            code;
   logic                            can_load;
   logic                            advance;
   logic                            req_take;

   assign advance   = in_valid_ff && can_load;
   assign req_stall = in_valid_ff && !can_load;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_value_in = in_value_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_value_in = req_value_bits;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      state_in = advance ? next_state : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff             <= 1'b0;
         state_ff.first_pending  <= 1'b1;
         state_ff.previous_value <= '0;
         state_ff.window_leading <= '0;
         state_ff.window_length  <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_value_ff <= in_value_in;
   end

   xfde_encoder u_encoder (
      .value_bits (in_value_ff),
      .state      (state_ff),
      .code       (code),
      .next_state (next_state)
   );

   xfde_out_buffer u_out_buffer (
      .clock           (clock),
      .reset           (reset),
      .load            (advance),
      .code            (code),
      .can_load        (can_load),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_bits   (rsp_code_bits),
      .rsp_code_length (rsp_code_length),
      .rsp_last_chunk  (rsp_last_chunk)
   );

endmodule

// File: dv/xfde_checker.sv
// Watches both channels of the XOR float delta encoder, predicts the code chunks of each
// accepted sample and compares them with the chunks that come out, in order.
// Depends on xfde_pkg for the chunk and state types and the code constants.
module xfde_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [xfde_pkg::ValueWidth-1:0] req_value_bits,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [xfde_pkg::ValueWidth-1:0] rsp_code_bits,
   input  logic [xfde_pkg::LenWidth-1:0]   rsp_code_length,
   input  logic                            rsp_last_chunk,
   output int                              fail_count,
   output int                              chunks_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   xfde_pkg::state_type encoder_state;
   xfde_pkg::chunk_type code_chunk_q[$];

   initial begin
      fail_count = 0;
      chunks_outstanding = 0;
   end

   function automatic logic [63:0] low_bits(input logic [63:0] v, input int len);
      logic [63:0] mask;
      mask = (len >= 64) ? '1 : ((64'h1 << len) - 64'h1);
      return v & mask;
   endfunction

   task automatic encode_sample(input logic [63:0] sample);
      logic [63:0] delta;
      logic [63:0] header;
      int          lead;
      int          trail;
      int          mlen;
      int          win_lead;
      int          win_len;
      int          win_trail;
      bit          reused;
      reused = 1'b0;
      if (encoder_state.first_pending) begin
         code_chunk_q.push_back(xfde_pkg::chunk_type'{bits: sample,
            length: xfde_pkg::FullLength, last: 1'b1});
         encoder_state.previous_value = sample;
         encoder_state.first_pending = 1'b0;
      end else begin
         delta = sample ^ encoder_state.previous_value;
         encoder_state.previous_value = sample;
         if (delta == 64'h0) begin
            code_chunk_q.push_back(xfde_pkg::chunk_type'{bits: 64'h0,
               length: xfde_pkg::ZeroLength, last: 1'b1});
         end else begin
            lead = 0;
            while (lead < 64 && !delta[63-lead]) lead++;
            if (lead > int'(xfde_pkg::LeadCap)) lead = int'(xfde_pkg::LeadCap);
            trail = 0;
            while (trail < 64 && !delta[trail]) trail++;
            mlen = 64 - lead - trail;
            win_lead = int'(encoder_state.window_leading);
            win_len = int'(encoder_state.window_length);
            if (win_len > 0 && win_lead + win_len <= 64) begin
               win_trail = 64 - win_lead - win_len;
               if (lead >= win_lead && trail >= win_trail) begin
                  reused = 1'b1;
                  code_chunk_q.push_back(xfde_pkg::chunk_type'{bits: 64'(xfde_pkg::CtlReuse),
                     length: xfde_pkg::ReuseHeaderLength, last: 1'b0});
                  code_chunk_q.push_back(xfde_pkg::chunk_type'{
                     bits: low_bits(delta >> win_trail, win_len),
                     length: win_len[xfde_pkg::LenWidth-1:0], last: 1'b1});
               end
            end
            if (!reused) begin
               header = (64'(xfde_pkg::CtlNewWindow)
                         << (xfde_pkg::LeadWidth + xfde_pkg::MlenWidth))
                        | (64'(lead) << xfde_pkg::MlenWidth) | 64'(mlen - 1);
               code_chunk_q.push_back(xfde_pkg::chunk_type'{bits: header,
                  length: xfde_pkg::NewHeaderLength, last: 1'b0});
               code_chunk_q.push_back(xfde_pkg::chunk_type'{
                  bits: low_bits(delta >> trail, mlen),
                  length: mlen[xfde_pkg::LenWidth-1:0], last: 1'b1});
               encoder_state.window_leading = lead[xfde_pkg::LeadWidth-1:0];
               encoder_state.window_length = mlen[xfde_pkg::LenWidth-1:0];
            end
         end
      end
   endtask

   task automatic check_chunk();
      xfde_pkg::chunk_type want;
      if (code_chunk_q.size() == 0) begin
         $display("%0t: unexpected chunk bits=%h length=%0d last=%0b", $time,
            rsp_code_bits, rsp_code_length, rsp_last_chunk);
         fail_count++;
      end else begin
         want = code_chunk_q.pop_front();
         if (rsp_code_bits !== want.bits) begin
            $display("%0t: code_bits expected %h actual %h", $time, want.bits, rsp_code_bits);
            fail_count++;
         end
         if (rsp_code_length !== want.length) begin
            $display("%0t: code_length expected %0d actual %0d", $time, want.length,
               rsp_code_length);
            fail_count++;
         end
         if (rsp_last_chunk !== want.last) begin
            $display("%0t: last_chunk expected %0b actual %0b", $time, want.last,
               rsp_last_chunk);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         encoder_state.first_pending = 1'b1;
         encoder_state.previous_value = '0;
         encoder_state.window_leading = '0;
         encoder_state.window_length = '0;
         code_chunk_q.delete();
      end else begin
         if (req_valid && !req_stall) encode_sample(req_value_bits);
         if (rsp_valid && !rsp_stall) check_chunk();
      end
      chunks_outstanding <= code_chunk_q.size();
   end

endmodule

// File: dv/tb_top.sv
// Top of the XOR float delta encoder testbench: clock, reset, sample stimulus with
// sender gaps and receiver stalls, and the final verdict. Depends on the encoder RTL,
// xfde_pkg and the xfde_checker module.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 300000;
   localparam int PhaseItems = 233;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_value_bits = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_code_bits;
   logic [6:0]  rsp_code_length;
   logic        rsp_last_chunk;
   int          fail_count;
   int          chunks_outstanding;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   logic [63:0] last_sample = '0;
   logic [63:0] last_mask = 64'hFF;

   xor_float_delta_encoder_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value_bits  (req_value_bits),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_bits   (rsp_code_bits),
      .rsp_code_length (rsp_code_length),
      .rsp_last_chunk  (rsp_last_chunk)
   );

   xfde_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_value_bits     (req_value_bits),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_code_bits      (rsp_code_bits),
      .rsp_code_length    (rsp_code_length),
      .rsp_last_chunk     (rsp_last_chunk),
      .fail_count         (fail_count),
      .chunks_outstanding (chunks_outstanding)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("xor_float_delta_encoder_unit verification failed");
         $finish;
      end
   end

   // entered and left at a falling edge
   task automatic send_sample(input logic [63:0] sample);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_value_bits <= {$urandom, $urandom};
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value_bits <= sample;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      last_sample = sample;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (chunks_outstanding != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic send_random_sample();
      logic [63:0] ones;
      logic [63:0] delta;
      int          lo;
      int          w;
      ones = '1;
      case ($urandom_range(9))
         0, 1: delta = '0;
         2, 3, 4, 5: begin
            lo = $urandom_range(63);
            w = $urandom_range(1, 64 - lo);
            last_mask = (ones >> (64 - w)) << lo;
            delta = {$urandom, $urandom} & last_mask;
         end
         6, 7: delta = {$urandom, $urandom} & last_mask;
         8: delta = last_sample ^ {$urandom, $urandom};
         default: delta = 64'h1 << $urandom_range(63);
      endcase
      send_sample(last_sample ^ delta);
   endtask

   initial begin
      logic [63:0] deltas[$];
      deltas = '{64'h0, 64'h0000_0FF0_0000_0000, 64'h0000_0110_0000_0000, 64'h1, 64'h2,
                 64'h8000_0000_0000_0001, 64'h0000_0000_0001_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                 64'h0, 64'h0000_0001_0000_0000, 64'h0000_0001_8000_0000,
                 64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 9;
      recv_stall_pct = 75;
      send_sample(64'h4009_21FB_5444_2D18);
      foreach (deltas[i]) send_sample(last_sample ^ deltas[i]);
      send_sample(64'h0);
      send_sample(64'hFFFF_FFFF_FFFF_FFFF);
      send_sample(64'h0);
      send_sample(64'h0);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 75 : 0;
         recv_stall_pct = (phase == 0) ? 75 : (phase == 1) ? 9 : 0;
         for (int i = 0; i < PhaseItems; i++) begin
            if (i == PhaseItems / 2) wait_drained();
            send_random_sample();
         end
         wait_drained();
      end

      if (fail_count == 0 && chunks_outstanding == 0) begin
         $display("xor_float_delta_encoder_unit verification clean");
      end else begin
         $display("xor_float_delta_encoder_unit verification failed");
      end
      $finish;
   end

endmodule
